FILE: hdl/swsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsb_pkg
// Shared types and constants of the sliding window sample buffer.
// ----------------------------------------------------------------------------
package swsb_pkg;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int WSIZE_W  = 7;
  localparam int AGE_W    = 6;
  localparam int FILL_W   = 7;

  // default ring depth
  localparam int DEFAULT_MAX_DEPTH = 64;

  // window size after reset
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd64;

  // request codes
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_MEAN  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

endpackage

FILE: hdl/swsb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsb_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module swsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/swsb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsb_div
// Restoring divider, one quotient bit per cycle, unsigned dividend by the
// window size.
// ----------------------------------------------------------------------------
module swsb_div
  import swsb_pkg::*;
#(
  parameter int DIVIDEND_W = 38
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [WSIZE_W-1:0]    divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  running;
  logic [CNT_W-1:0]      cnt;
  logic [WSIZE_W-1:0]    rem;
  logic [WSIZE_W-1:0]    dvs;
  logic [WSIZE_W:0]      trial;
  logic                  fits;

  // trial subtract of the shifted remainder
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIVIDEND_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      if (fits) begin
        rem      <= WSIZE_W'(trial - {1'b0, dvs});
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem      <= trial[WSIZE_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/sliding_window_sample_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_sample_buffer
// Ring store of recent samples with read by age and moving mean.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// shows on the result ports for one cycle with done high, and the receiver
// cannot stall it. A push or a read by age first reads the sample RAM, then
// writes back and registers the result. A mean is formed by the divider,
// one quotient bit per cycle over the 64-bit running total. A clear answers
// in the next cycle and then keeps busy high while it zeroes the RAM one
// entry a cycle; the same clearing pass runs after reset. The window size
// may be written at any idle time.
// ----------------------------------------------------------------------------
module sliding_window_sample_buffer
  import swsb_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [WSIZE_W-1:0]         cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic [AGE_W-1:0]           age,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] result_value,
  output logic [FILL_W-1:0]          fill_level,
  output logic                       read_valid
);

  localparam int AW = $clog2(MAX_DEPTH);
  // running total kept wide enough that stale samples never wrap it
  localparam int TW = 64;
  localparam int CW = ((AW > WSIZE_W) ? AW : WSIZE_W) + 1;
  localparam logic [WSIZE_W-1:0] NCAP =
    (MAX_DEPTH > 127) ? 7'd127 : WSIZE_W'(MAX_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t                state;
  logic [WSIZE_W-1:0]    window_size;
  logic [AW-1:0]         newest_slot;
  logic [FILL_W-1:0]     fill_count;
  logic [TW-1:0]         window_total;
  logic [AW-1:0]         sweep;

  req_t                  req;
  req_t                  req_r;
  logic [SAMPLE_W-1:0]   sample_r;
  logic [AW-1:0]         slot_r;
  logic                  valid_r;

  logic                  accept;
  logic [WSIZE_W-1:0]    n;
  logic [FILL_W-1:0]     limit;
  logic [CW-1:0]         newest_ext;
  logic [CW-1:0]         n_ext;
  logic [CW-1:0]         age_ext;
  logic [CW-1:0]         push_slot;
  logic [CW-1:0]         read_slot;
  logic                  read_ok;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SAMPLE_W-1:0]   ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [SAMPLE_W-1:0]   ram_rdata;

  logic                  full;
  logic [FILL_W-1:0]     fill_next;
  logic [TW-1:0]         old_ext;
  logic [TW-1:0]         new_ext;
  logic [TW-1:0]         total_next;

  logic                  div_start;
  logic                  div_done;
  logic [TW-1:0]         div_mag;
  logic [TW-1:0]         div_quo;
  logic [TW-1:0]         mean_q;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign req    = req_t'(req_type);

  // effective window size, clamped to 1..MAX_DEPTH and to at most 127
  always_comb begin
    if (window_size == '0) begin
      n = WSIZE_W'(1);
    end else if (window_size > NCAP) begin
      n = NCAP;
    end else begin
      n = window_size;
    end
  end

  // slot of the next push and of a read by age
  assign newest_ext = CW'(newest_slot);
  assign n_ext      = CW'(n);
  assign age_ext    = CW'(age);
  assign limit      = (fill_count < n) ? fill_count : n;

  always_comb begin
    if (fill_count != '0) begin
      push_slot = (newest_ext + CW'(1) >= n_ext) ? '0 : newest_ext + CW'(1);
    end else begin
      push_slot = newest_ext;
    end
    if (newest_ext >= age_ext) begin
      read_slot = newest_ext - age_ext;
    end else begin
      read_slot = newest_ext + n_ext - age_ext;
    end
  end

  assign read_ok = (age_ext < CW'(limit)) && (read_slot < CW'(MAX_DEPTH));

  // ram read address chosen by the incoming request
  assign ram_raddr = (req == REQ_PUSH) ? push_slot[AW-1:0] : read_slot[AW-1:0];

  // ram write: clearing pass or push write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = sample_r;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep;
      ram_wdata = '0;
    end else if (state == ST_EXEC && req_r == REQ_PUSH) begin
      ram_we = 1'b1;
    end
  end

  swsb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // push update of count and running total
  assign full       = fill_count >= n;
  assign fill_next  = (fill_count < n) ? fill_count + 1'b1 : n;
  assign old_ext    = full ? {{(TW-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata} : '0;
  assign new_ext    = {{(TW-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
  assign total_next = window_total - old_ext + new_ext;

  // mean divider on the magnitude of the total
  assign div_start = accept && (req == REQ_MEAN);
  assign div_mag   = window_total[TW-1] ? TW'(0) - window_total : window_total;

  swsb_div #(
    .DIVIDEND_W (TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (n),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign mean_q = window_total[TW-1] ? TW'(0) - div_quo : div_quo;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
    end else if (cfg_write) begin
      window_size <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= req;
      sample_r <= sample_value;
      slot_r   <= push_slot[AW-1:0];
      valid_r  <= read_ok;
    end
  end

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      sweep        <= '0;
      newest_slot  <= '0;
      fill_count   <= '0;
      window_total <= '0;
      done         <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= accept && (req == REQ_CLEAR);
          if (accept) begin
            case (req)
              REQ_PUSH, REQ_READ: begin
                state <= ST_EXEC;
              end
              REQ_MEAN: begin
                state <= ST_DIV;
              end
              default: begin
                newest_slot  <= '0;
                fill_count   <= '0;
                window_total <= '0;
                sweep        <= '0;
                state        <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_EXEC: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (req_r == REQ_PUSH) begin
            newest_slot  <= slot_r;
            fill_count   <= fill_next;
            window_total <= total_next;
          end
        end
        ST_DIV: begin
          done <= div_done;
          if (div_done) begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          done  <= 1'b0;
          sweep <= sweep + 1'b1;
          if (sweep == AW'(MAX_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        result_value <= '0;
        fill_level   <= '0;
        read_valid   <= 1'b1;
      end
      ST_EXEC: begin
        if (req_r == REQ_PUSH) begin
          result_value <= '0;
          fill_level   <= fill_next;
          read_valid   <= 1'b1;
        end else begin
          result_value <= valid_r ? ram_rdata : '0;
          fill_level   <= fill_count;
          read_valid   <= valid_r;
        end
      end
      ST_DIV: begin
        result_value <= mean_q[SAMPLE_W-1:0];
        fill_level   <= fill_count;
        read_valid   <= 1'b1;
      end
      default: begin
        result_value <= '0;
        fill_level   <= '0;
        read_valid   <= 1'b1;
      end
    endcase
  end

  // push and read raise done once the request has passed through the EXEC state
  a_rw_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (req == REQ_PUSH || req == REQ_READ)) |-> ##2 done)
    else $error("push or read result missing");

  // a rejected read carries a zero value
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !read_valid) |-> (result_value == '0))
    else $error("invalid read with nonzero value");

  // fill count bounded by the largest window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= NCAP)
    else $error("fill count beyond window");

  // ram written only while a request or clearing pass is in flight
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("ram write while idle");

  // newest slot stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    CW'(newest_slot) < CW'(MAX_DEPTH))
    else $error("newest slot out of range");

endmodule
